FILE: rtl/irts_pkg.sv
// ----------------------------------------------------------------------------
// irts_pkg: shared definitions for the I2C register transfer sequencer
// Command and bus condition codes, the default store depth and the result type.
// ----------------------------------------------------------------------------
`default_nettype none

package irts_pkg;

  localparam int DEFAULT_BUFFER_DEPTH = 32;

  localparam logic [2:0] CMD_LOAD        = 3'd0;
  localparam logic [2:0] CMD_START_WRITE = 3'd1;
  localparam logic [2:0] CMD_START_READ  = 3'd2;
  localparam logic [2:0] CMD_TX_READY    = 3'd3;
  localparam logic [2:0] CMD_RX_BYTE     = 3'd4;

  localparam logic [2:0] COND_NONE         = 3'd0;
  localparam logic [2:0] COND_START_TX     = 3'd1;
  localparam logic [2:0] COND_RESTART_RX   = 3'd2;
  localparam logic [2:0] COND_STOP         = 3'd3;
  localparam logic [2:0] COND_RESTART_STOP = 3'd4;

  typedef struct packed {
    logic [2:0] mode;
    logic       send_valid;
    logic [7:0] send_byte;
    logic [2:0] bus_condition;
    logic [6:0] bus_target;
    logic       received_valid;
    logic [7:0] received_byte;
    logic [4:0] received_index;
    logic       transfer_done;
  } irts_result_t;

endpackage

`default_nettype wire

FILE: rtl/irts_ram.sv
// ----------------------------------------------------------------------------
// irts_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module irts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/irts_ctrl.sv
// ----------------------------------------------------------------------------
// irts_ctrl: transfer sequencing state and transmit store
// Works out the next state and the result of one transaction combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module irts_ctrl
  import irts_pkg::*;
#(
  parameter int BUFFER_DEPTH = DEFAULT_BUFFER_DEPTH
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         accept,
  input  wire logic [2:0]   command,
  input  wire logic [6:0]   target_address,
  input  wire logic [7:0]   register_address,
  input  wire logic [5:0]   byte_count,
  input  wire logic [4:0]   buffer_index,
  input  wire logic [7:0]   data_byte,
  output irts_result_t      result
);

  localparam int IDX_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_SEND_REG  = 3'd1,
    PH_SWITCH_RX = 3'd2,
    PH_SEND_DATA = 3'd3,
    PH_RECEIVE   = 3'd4
  } phase_t;

  phase_t           phase, phase_next;
  logic [6:0]       target_reg, target_reg_next;
  logic [7:0]       register_byte, register_byte_next;
  logic [CNT_W-1:0] send_remaining, send_remaining_next;
  logic [IDX_W-1:0] send_position, send_position_next;
  logic [CNT_W-1:0] receive_remaining, receive_remaining_next;
  logic [4:0]       receive_position, receive_position_next;

  logic             store_we;
  logic [IDX_W-1:0] store_waddr;
  logic [7:0]       store_rdata;
  logic             bypass;
  logic [7:0]       bypass_data;
  logic [7:0]       store_byte;
  logic [CNT_W-1:0] count_sat;

  assign store_we    = accept && (command == CMD_LOAD) && (int'(buffer_index) < BUFFER_DEPTH);
  assign store_waddr = IDX_W'(buffer_index);

  // The store is read every cycle at the position the next send will use, so the
  // registered data always matches the current send position. A load to that
  // same position in the same cycle is forwarded around the RAM.
  irts_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (store_waddr),
    .wdata (data_byte),
    .raddr (send_position_next),
    .rdata (store_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      bypass <= 1'b0;
    end else begin
      bypass <= store_we && (store_waddr == send_position_next);
    end
    bypass_data <= data_byte;
  end

  assign store_byte = bypass ? bypass_data : store_rdata;
  assign count_sat  = (int'(byte_count) > BUFFER_DEPTH) ? CNT_W'(BUFFER_DEPTH)
                                                        : CNT_W'(byte_count);

  always_comb begin
    phase_next             = phase;
    target_reg_next        = target_reg;
    register_byte_next     = register_byte;
    send_remaining_next    = send_remaining;
    send_position_next     = send_position;
    receive_remaining_next = receive_remaining;
    receive_position_next  = receive_position;
    result                 = '0;

    if (accept) begin
      case (command) inside
        CMD_START_WRITE, CMD_START_READ: begin
          phase_next             = PH_SEND_REG;
          target_reg_next        = target_address;
          register_byte_next     = register_address;
          send_remaining_next    = (command == CMD_START_READ) ? '0 : count_sat;
          receive_remaining_next = (command == CMD_START_READ) ? count_sat : '0;
          send_position_next     = '0;
          receive_position_next  = '0;
          result.bus_condition   = COND_START_TX;
        end
        CMD_TX_READY: begin
          unique case (phase)
            PH_SEND_REG: begin
              result.send_valid = 1'b1;
              result.send_byte  = register_byte;
              phase_next = (receive_remaining != '0) ? PH_SWITCH_RX : PH_SEND_DATA;
            end
            PH_SWITCH_RX: begin
              phase_next = PH_RECEIVE;
              result.bus_condition = (receive_remaining == CNT_W'(1)) ? COND_RESTART_STOP
                                                                      : COND_RESTART_RX;
            end
            PH_SEND_DATA: begin
              if (send_remaining != '0) begin
                result.send_valid   = 1'b1;
                result.send_byte    = store_byte;
                send_position_next  = send_position + IDX_W'(1);
                send_remaining_next = send_remaining - CNT_W'(1);
              end else begin
                result.bus_condition = COND_STOP;
                result.transfer_done = 1'b1;
                phase_next           = PH_IDLE;
              end
            end
            default: begin
            end
          endcase
        end
        CMD_RX_BYTE: begin
          if (phase == PH_RECEIVE) begin
            if (receive_remaining != '0) begin
              result.received_valid  = 1'b1;
              result.received_byte   = data_byte;
              result.received_index  = receive_position;
              receive_position_next  = receive_position + 5'd1;
              receive_remaining_next = receive_remaining - CNT_W'(1);
            end
            if (receive_remaining_next == CNT_W'(1)) begin
              result.bus_condition = COND_STOP;
            end else if (receive_remaining_next == '0) begin
              result.transfer_done = 1'b1;
              phase_next           = PH_IDLE;
            end
          end
        end
        default: begin
        end
      endcase
    end

    result.mode = phase_next;
    if (result.bus_condition == COND_START_TX || result.bus_condition == COND_RESTART_RX ||
        result.bus_condition == COND_RESTART_STOP) begin
      result.bus_target = target_reg_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_IDLE;
      target_reg        <= '0;
      register_byte     <= '0;
      send_remaining    <= '0;
      send_position     <= '0;
      receive_remaining <= '0;
      receive_position  <= '0;
    end else begin
      phase             <= phase_next;
      target_reg        <= target_reg_next;
      register_byte     <= register_byte_next;
      send_remaining    <= send_remaining_next;
      send_position     <= send_position_next;
      receive_remaining <= receive_remaining_next;
      receive_position  <= receive_position_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/irts_out_reg.sv
// ----------------------------------------------------------------------------
// irts_out_reg: result register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module irts_out_reg
  import irts_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          load,
  input  wire irts_result_t  result_in,
  input  wire logic          out_ready,
  output logic               out_valid,
  output logic               can_load,
  output irts_result_t       result_out
);

  // A new result may enter while the held one is taken in the same cycle.
  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (load) begin
      result_out <= result_in;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/i2c_register_transfer_sequencer_top.sv
// ----------------------------------------------------------------------------
// i2c_register_transfer_sequencer_top: I2C register write/read sequencer
// Loads a transmit store and steps a register transfer one bus event at a time.
// ----------------------------------------------------------------------------
// Latency: a result appears in the cycle after its transaction is accepted.
// Throughput: one transaction per cycle while the result register is not stalled
// by out_ready; the state update and the store read, prefetched at the next send position, never hold off the input.
// Reset: synchronous rst returns the sequencer to idle with all counters cleared;
// the transmit store is not cleared and holds what was last loaded.
`default_nettype none

module i2c_register_transfer_sequencer_top
  import irts_pkg::*;
#(
  parameter int BUFFER_DEPTH = DEFAULT_BUFFER_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [2:0] command,
  input  wire logic [6:0] target_address,
  input  wire logic [7:0] register_address,
  input  wire logic [5:0] byte_count,
  input  wire logic [4:0] buffer_index,
  input  wire logic [7:0] data_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [2:0]      mode,
  output logic            send_valid,
  output logic [7:0]      send_byte,
  output logic [2:0]      bus_condition,
  output logic [6:0]      bus_target,
  output logic            received_valid,
  output logic [7:0]      received_byte,
  output logic [4:0]      received_index,
  output logic            transfer_done
);

  logic         accept;
  irts_result_t next_result;
  irts_result_t held_result;

  assign accept = in_valid && in_ready;

  irts_ctrl #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .command          (command),
    .target_address   (target_address),
    .register_address (register_address),
    .byte_count       (byte_count),
    .buffer_index     (buffer_index),
    .data_byte        (data_byte),
    .result           (next_result)
  );

  irts_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (accept),
    .result_in  (next_result),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .can_load   (in_ready),
    .result_out (held_result)
  );

  assign mode           = held_result.mode;
  assign send_valid     = held_result.send_valid;
  assign send_byte      = held_result.send_byte;
  assign bus_condition  = held_result.bus_condition;
  assign bus_target     = held_result.bus_target;
  assign received_valid = held_result.received_valid;
  assign received_byte  = held_result.received_byte;
  assign received_index = held_result.received_index;
  assign transfer_done  = held_result.transfer_done;

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && transfer_done |-> mode == 3'd0)
    else $error("transfer done reported without returning to idle");

  a_one_direction: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(send_valid && received_valid))
    else $error("send and receive reported in the same transaction");

  a_target_with_start: assert property (@(posedge clk) disable iff (rst)
    out_valid && (bus_condition == COND_NONE || bus_condition == COND_STOP)
      |-> bus_target == 7'd0)
    else $error("bus target driven without a start condition");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while the result register is stalled");

endmodule

`default_nettype wire

FILE: verif/i2c_register_transfer_sequencer_top_test.sv
// ----------------------------------------------------------------------------
// i2c_register_transfer_sequencer_top_test: self-checking bench for the sequencer
// Drives a short table of bus events, then well-formed random register
// transfers with some noise; checks each result against its prediction or a
// checked row's typed result, under several patterns of idling and back-pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module i2c_register_transfer_sequencer_top_test;
  import irts_pkg::*;

  localparam int BUF_DEPTH = DEFAULT_BUFFER_DEPTH;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 395;

  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  typedef enum logic [2:0] {
    ST_IDLE      = 3'd0,
    ST_SEND_REG  = 3'd1,
    ST_SWITCH_RX = 3'd2,
    ST_SEND_DATA = 3'd3,
    ST_RECEIVE   = 3'd4
  } seq_phase_t;

  typedef struct packed {
    logic [2:0]   command;
    logic [6:0]   target_address;
    logic [7:0]   register_address;
    logic [5:0]   byte_count;
    logic [4:0]   buffer_index;
    logic [7:0]   data_byte;
    logic         checked;
    irts_result_t want;
  } bus_event_t;

  localparam irts_result_t IDLE_QUIET = '0;

  // Rows with checked set carry a typed result; the rest are predicted.
  localparam bus_event_t DIRECTED_ROWS [26] = '{
    '{CMD_TX_READY, 7'd0, 8'h00, 6'd0, 5'd0, 8'h00, 1'b1, IDLE_QUIET},
    '{CMD_RX_BYTE, 7'd0, 8'h00, 6'd0, 5'd0, 8'hFF, 1'b1, IDLE_QUIET},
    '{CMD_SPARE_HI, 7'd127, 8'hFF, 6'd63, 5'd31, 8'hFF, 1'b1, IDLE_QUIET},
    '{CMD_LOAD, 7'd0, 8'h00, 6'd0, 5'd31, 8'h00, 1'b1, IDLE_QUIET},
    '{CMD_LOAD, 7'd0, 8'h00, 6'd0, 5'd0, 8'hFF, 1'b1, IDLE_QUIET},
    '{CMD_START_WRITE, 7'd127, 8'hFF, 6'd2, 5'd0, 8'h00, 1'b1,
      '{ST_SEND_REG, 1'b0, 8'h00, COND_START_TX, 7'd127, 1'b0, 8'h00, 5'd0, 1'b0}},
    '{CMD_TX_READY, 7'd0, 8'h00, 6'd0, 5'd0, 8'h00, 1'b1,
      '{ST_SEND_DATA, 1'b1, 8'hFF, COND_NONE, 7'd0, 1'b0, 8'h00, 5'd0, 1'b0}},
    '{CMD_TX_READY, 7'd0, 8'h00, 6'd0, 5'd0, 8'h00, 1'b0, IDLE_QUIET},
    // Loads the very position that is to be sent next.
    '{CMD_LOAD, 7'd0, 8'h00, 6'd0, 5'd1, 8'h3C, 1'b0, IDLE_QUIET},
    '{CMD_TX_READY, 7'd0, 8'h00, 6'd0, 5'd0, 8'h00, 1'b0, IDLE_QUIET},
    '{CMD_TX_READY, 7'd0, 8'h00, 6'd0, 5'd0, 8'h00, 1'b1,
      '{ST_IDLE, 1'b0, 8'h00, COND_STOP, 7'd0, 1'b0, 8'h00, 5'd0, 1'b1}},
    '{CMD_START_READ, 7'd0, 8'h00, 6'd1, 5'd0, 8'h00, 1'b1,
      '{ST_SEND_REG, 1'b0, 8'h00, COND_START_TX, 7'd0, 1'b0, 8'h00, 5'd0, 1'b0}},
    '{CMD_TX_READY, 7'd0, 8'h00, 6'd0, 5'd0, 8'h00, 1'b1,
      '{ST_SWITCH_RX, 1'b1, 8'h00, COND_NONE, 7'd0, 1'b0, 8'h00, 5'd0, 1'b0}},
    '{CMD_TX_READY, 7'd0, 8'h00, 6'd0, 5'd0, 8'h00, 1'b1,
      '{ST_RECEIVE, 1'b0, 8'h00, COND_RESTART_STOP, 7'd0, 1'b0, 8'h00, 5'd0, 1'b0}},
    '{CMD_RX_BYTE, 7'd0, 8'h00, 6'd0, 5'd0, 8'hFF, 1'b0, IDLE_QUIET},
    // A read of no bytes behaves as a write of no bytes.
    '{CMD_START_READ, 7'd42, 8'h81, 6'd0, 5'd0, 8'h00, 1'b0, IDLE_QUIET},
    '{CMD_TX_READY, 7'd0, 8'h00, 6'd0, 5'd0, 8'h00, 1'b0, IDLE_QUIET},
    '{CMD_TX_READY, 7'd0, 8'h00, 6'd0, 5'd0, 8'h00, 1'b0, IDLE_QUIET},
    // The count saturates at the store depth.
    '{CMD_START_READ, 7'd85, 8'h5A, 6'd63, 5'd0, 8'h00, 1'b0, IDLE_QUIET},
    '{CMD_TX_READY, 7'd0, 8'h00, 6'd0, 5'd0, 8'h00, 1'b0, IDLE_QUIET},
    '{CMD_TX_READY, 7'd0, 8'h00, 6'd0, 5'd0, 8'h00, 1'b0, IDLE_QUIET},
    '{CMD_RX_BYTE, 7'd0, 8'h00, 6'd0, 5'd0, 8'h00, 1'b0, IDLE_QUIET},
    '{CMD_TX_READY, 7'd0, 8'h00, 6'd0, 5'd0, 8'h00, 1'b0, IDLE_QUIET},
    // A start in the middle of a read abandons it.
    '{CMD_START_WRITE, 7'd1, 8'h00, 6'd0, 5'd0, 8'h00, 1'b0, IDLE_QUIET},
    '{CMD_TX_READY, 7'd0, 8'h00, 6'd0, 5'd0, 8'h00, 1'b0, IDLE_QUIET},
    '{CMD_TX_READY, 7'd0, 8'h00, 6'd0, 5'd0, 8'h00, 1'b0, IDLE_QUIET}
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [2:0] command = '0;
  logic [6:0] target_address = '0;
  logic [7:0] register_address = '0;
  logic [5:0] byte_count = '0;
  logic [4:0] buffer_index = '0;
  logic [7:0] data_byte = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] mode;
  logic       send_valid;
  logic [7:0] send_byte;
  logic [2:0] bus_condition;
  logic [6:0] bus_target;
  logic       received_valid;
  logic [7:0] received_byte;
  logic [4:0] received_index;
  logic       transfer_done;

  i2c_register_transfer_sequencer_top DUT (
    .clk, .rst, .in_valid, .in_ready, .command, .target_address, .register_address,
    .byte_count, .buffer_index, .data_byte, .out_valid, .out_ready, .mode,
    .send_valid, .send_byte, .bus_condition, .bus_target, .received_valid,
    .received_byte, .received_index, .transfer_done
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predicted sequencer state.
  seq_phase_t seq_phase = ST_IDLE;
  logic [6:0] seq_target = '0;
  logic [7:0] seq_register = '0;
  logic [5:0] writes_left = '0;
  logic [5:0] write_pos = '0;
  logic [5:0] reads_left = '0;
  logic [5:0] read_pos = '0;
  logic [7:0] store_image [BUF_DEPTH];

  bus_event_t   pending_events [$];
  irts_result_t expected_results [$];
  bus_event_t   offer;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           mismatch_count = 0;
  bit           hold_req = 1'b0;
  int           hold_left = 0;

  function automatic irts_result_t advance_sequencer(bus_event_t ev);
    irts_result_t r;
    logic [5:0]   n;
    r = '0;
    n = (ev.byte_count > BUF_DEPTH) ? 6'(BUF_DEPTH) : ev.byte_count;
    case (ev.command)
      CMD_LOAD: store_image[ev.buffer_index] = ev.data_byte;
      CMD_START_WRITE, CMD_START_READ: begin
        seq_phase = ST_SEND_REG;
        seq_target = ev.target_address;
        seq_register = ev.register_address;
        writes_left = (ev.command == CMD_START_READ) ? 6'd0 : n;
        reads_left = (ev.command == CMD_START_READ) ? n : 6'd0;
        write_pos = '0;
        read_pos = '0;
        r.bus_condition = COND_START_TX;
      end
      CMD_TX_READY: begin
        case (seq_phase)
          ST_SEND_REG: begin
            r.send_valid = 1'b1;
            r.send_byte = seq_register;
            seq_phase = (reads_left != 0) ? ST_SWITCH_RX : ST_SEND_DATA;
          end
          ST_SWITCH_RX: begin
            seq_phase = ST_RECEIVE;
            r.bus_condition = (reads_left == 1) ? COND_RESTART_STOP : COND_RESTART_RX;
          end
          ST_SEND_DATA: begin
            if (writes_left != 0) begin
              r.send_valid = 1'b1;
              r.send_byte = (write_pos < BUF_DEPTH) ? store_image[write_pos[4:0]] : 8'h00;
              write_pos++;
              writes_left--;
            end else begin
              r.bus_condition = COND_STOP;
              r.transfer_done = 1'b1;
              seq_phase = ST_IDLE;
            end
          end
          default: ;
        endcase
      end
      CMD_RX_BYTE: begin
        if (seq_phase == ST_RECEIVE) begin
          if (reads_left != 0) begin
            r.received_valid = 1'b1;
            r.received_byte = ev.data_byte;
            r.received_index = read_pos[4:0];
            read_pos++;
            reads_left--;
          end
          if (reads_left == 1) begin
            r.bus_condition = COND_STOP;
          end else if (reads_left == 0) begin
            r.transfer_done = 1'b1;
            seq_phase = ST_IDLE;
          end
        end
      end
      default: ;
    endcase
    r.mode = seq_phase;
    if (r.bus_condition == COND_START_TX || r.bus_condition == COND_RESTART_RX ||
        r.bus_condition == COND_RESTART_STOP)
      r.bus_target = seq_target;
    return r;
  endfunction

  function automatic string describe(irts_result_t r);
    return $sformatf("mode=%0d send=%0b/%02h cond=%0d tgt=%02h rx=%0b/%02h idx=%0d done=%0b",
                     r.mode, r.send_valid, r.send_byte, r.bus_condition, r.bus_target,
                     r.received_valid, r.received_byte, r.received_index, r.transfer_done);
  endfunction

  function automatic bus_event_t random_event(logic [2:0] cmd);
    bus_event_t ev;
    ev.command = cmd;
    ev.target_address = 7'($urandom);
    ev.register_address = 8'($urandom);
    ev.byte_count = 6'($urandom);
    ev.buffer_index = 5'($urandom);
    ev.data_byte = 8'($urandom);
    ev.checked = 1'b0;
    ev.want = '0;
    return ev;
  endfunction

  // Mostly complete register transfers with random content; a few are cut
  // short, and stray events of any kind are mixed in.
  task automatic queue_random_transfers(int target_items);
    int         made;
    int         pick;
    int         n;
    bit         is_read;
    bus_event_t ev;
    made = 0;
    while (made < target_items) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        pending_events.push_back(random_event(3'($urandom_range(7))));
        made++;
      end else if (pick < 20) begin
        pending_events.push_back(random_event(CMD_LOAD));
        made++;
      end else begin
        is_read = 1'($urandom_range(1));
        ev = random_event(is_read ? CMD_START_READ : CMD_START_WRITE);
        pick = $urandom_range(99);
        if (pick < 70)
          ev.byte_count = 6'($urandom_range(4));
        else if (pick < 92)
          ev.byte_count = 6'($urandom_range(32, 5));
        else
          ev.byte_count = 6'($urandom_range(63, 33));
        pending_events.push_back(ev);
        made++;
        n = (ev.byte_count > BUF_DEPTH) ? BUF_DEPTH : int'(ev.byte_count);
        // Both a write and a read take the count plus two further events.
        for (int s = 0; s < n + 2; s++) begin
          if ($urandom_range(99) < 2) break;
          if ($urandom_range(99) < 4) begin
            pending_events.push_back(random_event(3'($urandom_range(7))));
            made++;
          end
          ev = random_event((is_read && n != 0 && s >= 2) ? CMD_RX_BYTE : CMD_TX_READY);
          pending_events.push_back(ev);
          made++;
        end
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_events.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  // Both handshakes are sampled here, results first, then the input side.
  always @(posedge clk) begin : handshakes
    irts_result_t got;
    irts_result_t want;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = {mode, send_valid, send_byte, bus_condition, bus_target, received_valid,
               received_byte, received_index, transfer_done};
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result transaction: %s", describe(got));
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("result mismatch\n  expected %s\n  actual   %s",
                       describe(want), describe(got));
          end
        end
      end
      if (in_valid && in_ready) begin
        want = advance_sequencer(offer);
        expected_results.push_back(offer.checked ? offer.want : want);
      end
      if (!in_valid || in_ready) begin
        if (pending_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offer = pending_events.pop_front();
          in_valid <= 1'b1;
          command <= offer.command;
          target_address <= offer.target_address;
          register_address <= offer.register_address;
          byte_count <= offer.byte_count;
          buffer_index <= offer.buffer_index;
          data_byte <= offer.data_byte;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    int         idle_plan [4];
    int         stall_plan [4];
    bus_event_t ev;
    idle_plan = '{0, 54, 0, 12};
    stall_plan = '{0, 0, 54, 12};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_plan[p];
      recv_stall_pct = stall_plan[p];
      if (p == 0) begin
        foreach (DIRECTED_ROWS[i]) pending_events.push_back(DIRECTED_ROWS[i]);
        // Fill the whole store so that no send ever reads an unwritten entry.
        for (int i = 0; i < BUF_DEPTH; i++) begin
          ev = random_event(CMD_LOAD);
          ev.buffer_index = 5'(i);
          pending_events.push_back(ev);
        end
        hold_req = 1'b1;
      end
      queue_random_transfers(PHASE_ITEMS);
      wait_drained();
    end
    repeat (10) @(negedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("PASS i2c_register_transfer_sequencer_top");
    end else begin
      $display("FAIL i2c_register_transfer_sequencer_top");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("FAIL i2c_register_transfer_sequencer_top");
    $finish;
  end

endmodule
